// ===== sv/fdam_pkg.sv =====
// ----------------------------------------------------------------------------
// fdam_pkg
// Shared types and constants for the fridge door alarm monitor.
// ----------------------------------------------------------------------------
package fdam_pkg;

    // Default length of the door-open history window.
    localparam int unsigned HistoryBitsDefault = 16;

    // Reset values of the configuration registers.
    localparam logic signed [7:0] TempLimitReset   = 8'sd25;
    localparam logic        [7:0] LightLimitReset  = 8'd200;
    localparam logic        [7:0] AlertLimitReset  = 8'd5;
    localparam logic        [7:0] LightReloadReset = 8'd20;

    // Backlight countdown value after reset.
    localparam logic [7:0] BacklightReset = 8'd30;

    // Saturation point of the full-window count.
    localparam logic [7:0] WindowsMax = 8'd255;

    // Configuration register indexes (byte address / 4).
    typedef enum logic [1:0] {
        REG_TEMP_LIMIT   = 2'd0,
        REG_LIGHT_LIMIT  = 2'd1,
        REG_ALERT_LIMIT  = 2'd2,
        REG_LIGHT_RELOAD = 2'd3
    } t_reg_index;

    // Display action codes.
    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_WARNING       = 3'd1,
        ACT_READINGS      = 3'd2,
        ACT_WAKE_WARNING  = 3'd3,
        ACT_WAKE_READINGS = 3'd4,
        ACT_SWITCH_OFF    = 3'd5
    } t_display_action;

endpackage

// ===== sv/fridge_door_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// fridge_door_alarm_monitor
// Judges the fridge door from temperature and light samples, raises a
// toggling beeper alarm after repeated full open windows and steers the
// display backlight.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  ----------------------------------
//  sample    in         i_valid / o_stall     temperature, light, button
//  result    out        o_valid / i_stall     door, close event, beeper, alarm,
//                                             display action/awake, alert level
//  config    in         APB (psel/penable)    four 8-bit limit registers
//
//  Each request is latched in an input register, evaluated by combinational
//  compare and shift logic and written to the result register, so one request
//  can be accepted every cycle while the result side does not stall.
//  The result register only advances when it is empty or being taken, so a
//  stall on the result side backs up into o_stall after one buffered request.
//  Reset is synchronous and active low; it restores all limits and state.
//  Configuration writes take effect immediately and are meant for idle time.
// ----------------------------------------------------------------------------
module fridge_door_alarm_monitor #(
    parameter int unsigned HISTORY_BITS = fdam_pkg::HistoryBitsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Sample channel.
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [7:0] i_temperature_inside,
    input  logic        [7:0] i_light_inside,
    input  logic              i_button_pressed,

    // Result channel.
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_door_open,
    output logic              o_door_closed_event,
    output logic              o_beeper,
    output logic              o_alarm_active,
    output logic        [2:0] o_display_action,
    output logic              o_display_awake,
    output logic        [7:0] o_alert_level,

    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic        [3:0] paddr,
    input  logic       [31:0] pwdata,
    output logic       [31:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------------
    // Configuration registers. The register index is the word address.
    // ------------------------------------------------------------------------
    logic signed [7:0] r_temp_limit;
    logic        [7:0] r_light_limit;
    logic        [7:0] r_alert_limit;
    logic        [7:0] r_light_reload;
    logic              cfg_write;
    fdam_pkg::t_reg_index cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = fdam_pkg::t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_limit   <= fdam_pkg::TempLimitReset;
            r_light_limit  <= fdam_pkg::LightLimitReset;
            r_alert_limit  <= fdam_pkg::AlertLimitReset;
            r_light_reload <= fdam_pkg::LightReloadReset;
        end else if (cfg_write) begin
            unique case (cfg_index)
                fdam_pkg::REG_TEMP_LIMIT:   r_temp_limit   <= pwdata[7:0];
                fdam_pkg::REG_LIGHT_LIMIT:  r_light_limit  <= pwdata[7:0];
                fdam_pkg::REG_ALERT_LIMIT:  r_alert_limit  <= pwdata[7:0];
                fdam_pkg::REG_LIGHT_RELOAD: r_light_reload <= pwdata[7:0];
            endcase
        end
    end

    // Reads return the register zero-extended; the sign of the temperature
    // limit lives in bit 7.
    always_comb begin
        unique case (cfg_index)
            fdam_pkg::REG_TEMP_LIMIT:   prdata = {24'd0, r_temp_limit};
            fdam_pkg::REG_LIGHT_LIMIT:  prdata = {24'd0, r_light_limit};
            fdam_pkg::REG_ALERT_LIMIT:  prdata = {24'd0, r_alert_limit};
            fdam_pkg::REG_LIGHT_RELOAD: prdata = {24'd0, r_light_reload};
        endcase
    end

    // ------------------------------------------------------------------------
    // Handshake. The input register advances into the result register when
    // the result register is empty or its content is taken this cycle.
    // ------------------------------------------------------------------------
    logic              r_in_valid;
    logic signed [7:0] r_in_temp;
    logic        [7:0] r_in_light;
    logic              r_in_button;
    logic              r_out_valid;
    logic              advance;
    logic              accept;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_temp   <= i_temperature_inside;
            r_in_light  <= i_light_inside;
            r_in_button <= i_button_pressed;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor state.
    // ------------------------------------------------------------------------
    logic [HISTORY_BITS-1:0] r_history;
    logic [7:0]              r_windows;
    logic                    r_alarm;
    logic                    r_was_open;
    logic                    r_beeper;
    logic [7:0]              r_count;
    logic                    r_screen;

    logic [HISTORY_BITS-1:0] n_history;
    logic [7:0]              n_windows;
    logic                    n_alarm;
    logic                    n_was_open;
    logic                    n_beeper;
    logic [7:0]              n_count;
    logic                    n_screen;
    logic                    n_open;
    logic                    n_closed_event;
    fdam_pkg::t_display_action n_action;

    // One tick of the monitor, in the order the steps interact: button and
    // running alarm reload the countdown, the door is judged, the history
    // window is checked, then the backlight countdown picks the display action.
    always_comb begin
        n_history      = r_history;
        n_windows      = r_windows;
        n_alarm        = r_alarm;
        n_was_open     = r_was_open;
        n_beeper       = r_beeper;
        n_count        = r_count;
        n_screen       = r_screen;
        n_closed_event = 1'b0;
        n_action       = fdam_pkg::ACT_NONE;

        if (r_in_button) begin
            n_count = r_light_reload;
        end
        if (r_alarm) begin
            n_beeper = !r_beeper;
            n_count  = r_light_reload;
        end

        n_open = (r_in_temp >= r_temp_limit) || (r_in_light <= r_light_limit);
        if (n_open) begin
            n_was_open = 1'b1;
            n_count    = r_light_reload;
        end else begin
            n_closed_event = r_was_open;
            n_was_open     = 1'b0;
            n_windows      = 8'd0;
            n_alarm        = 1'b0;
            n_beeper       = 1'b0;
        end

        n_history = {r_history[HISTORY_BITS-2:0], n_open};
        if (&n_history) begin
            n_history = '0;
            if (n_windows != fdam_pkg::WindowsMax) begin
                n_windows = n_windows + 8'd1;
            end
            if (n_windows > r_alert_limit) begin
                n_beeper = 1'b1;
                n_alarm  = 1'b1;
                n_count  = r_light_reload;
            end
        end

        priority if ((n_count != 8'd0) && r_screen) begin
            n_count  = n_count - 8'd1;
            n_action = n_open ? fdam_pkg::ACT_WARNING : fdam_pkg::ACT_READINGS;
        end else if (n_count != 8'd0) begin
            n_screen = 1'b1;
            n_action = n_open ? fdam_pkg::ACT_WAKE_WARNING
                              : fdam_pkg::ACT_WAKE_READINGS;
        end else if (r_screen) begin
            n_screen = 1'b0;
            n_action = fdam_pkg::ACT_SWITCH_OFF;
        end else begin
            n_action = fdam_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history  <= '0;
            r_windows  <= 8'd0;
            r_alarm    <= 1'b0;
            r_was_open <= 1'b0;
            r_beeper   <= 1'b0;
            r_count    <= fdam_pkg::BacklightReset;
            r_screen   <= 1'b1;
        end else if (advance) begin
            r_history  <= n_history;
            r_windows  <= n_windows;
            r_alarm    <= n_alarm;
            r_was_open <= n_was_open;
            r_beeper   <= n_beeper;
            r_count    <= n_count;
            r_screen   <= n_screen;
        end
    end

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_door_open         <= n_open;
            o_door_closed_event <= n_closed_event;
            o_beeper            <= n_beeper;
            o_alarm_active      <= n_alarm;
            o_display_action    <= n_action;
            o_display_awake     <= n_screen;
            o_alert_level       <= n_windows;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // The alarm only survives a tick that judged the door open.
    a_alarm_needs_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_alarm_active |-> o_door_open)
        else $error("alarm active on a closed-door tick");

    // A close event clears the alarm and the window count.
    a_close_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_door_closed_event |->
            !o_door_open && !o_alarm_active && !o_beeper && (o_alert_level == 8'd0))
        else $error("close event without cleared alarm state");

    // Switching off leaves the display dark, waking leaves it lit.
    a_display_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_display_action == fdam_pkg::ACT_SWITCH_OFF) |-> !o_display_awake)
        else $error("display still awake after switch off");

    a_wake_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_display_action == fdam_pkg::ACT_WAKE_WARNING) ||
                    (o_display_action == fdam_pkg::ACT_WAKE_READINGS)) |-> o_display_awake)
        else $error("display not awake after wake action");

    // A result that is not taken stays in place and blocks the next one.
    a_result_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && !$past(advance))
        else $error("stalled result overwritten");

endmodule
